[src/psfb_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// psfb_pkg: shared types and constants for the point set fit-to-box block
// Field widths, opcodes, register indexes, sequencer states, divider status.
// ============================================================================
package psfb_pkg;

    localparam int COORD_W    = 32;                  // signed Q16.16 coordinate
    localparam int FRAC_BITS  = 16;                  // fraction bits
    localparam int BOX_W      = 31;                  // unsigned box size
    localparam int MINEXT_W   = 16;                  // minimum extent register
    localparam int FACTOR_W   = 32;                  // unsigned Q16.16 factor
    localparam int DIVIDEND_W = BOX_W + FRAC_BITS;   // box size << FRAC_BITS
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
    localparam int PROD_W     = COORD_W + FACTOR_W;  // magnitude * factor
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [1:0] {
        OP_FIRST     = 2'd0,
        OP_FURTHER   = 2'd1,
        OP_TRANSFORM = 2'd2,
        OP_NOP       = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_WIDTH  = 2'd0,
        CFG_BOX_HEIGHT = 2'd1,
        CFG_FIT_MODE   = 2'd2,
        CFG_MIN_EXTENT = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y,
        ST_PICK,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

[src/point_set_fit_to_box.sv]
`timescale 1ns / 1ps
// ============================================================================
// point_set_fit_to_box: two-pass bounding box measure and fit-to-box transform
// Measure transactions grow a bounding box; transform transactions map each
// point into the target box using Q16.16 factors derived once per pass.
// ============================================================================
//
// Channel   Dir  Handshake            Payload
// point     in   point_valid/stall    opcode, x_in, y_in
// result    out  result_valid/stall   x_out, y_out
// cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Measure and no-op transactions finish in the accept cycle; the block stays
// ready. A transform passes through the shared scale unit (x then y) in the
// MUL_X, MUL_Y, MUL_DRAIN and EMIT states, after the bit-serial divider on the
// first transform after measuring. If the result register is still held by
// result_stall, the sequencer waits in its emit state. Reset clears the box,
// factors and registers to their defaults; no clearing pass is needed.
// cfg_ready is always high.
//
module point_set_fit_to_box
    import psfb_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       point_valid,
    output logic                       point_stall,
    input  logic [1:0]                 opcode,
    input  logic signed [COORD_W-1:0]  x_in,
    input  logic signed [COORD_W-1:0]  y_in,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic signed [COORD_W-1:0]  x_out,
    output logic signed [COORD_W-1:0]  y_out,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [BOX_W-1:0]           cfg_data
);

    state_t state_reg, state_next;

    // configuration registers
    logic [BOX_W-1:0]    box_width_reg, box_width_next;
    logic [BOX_W-1:0]    box_height_reg, box_height_next;
    logic                fit_mode_reg, fit_mode_next;
    logic [MINEXT_W-1:0] min_extent_reg, min_extent_next;

    // bounding box and factors
    logic signed [COORD_W-1:0] min_x_reg, min_x_next, max_x_reg, max_x_next;
    logic signed [COORD_W-1:0] min_y_reg, min_y_next, max_y_reg, max_y_next;
    logic [FACTOR_W-1:0]       factor_x_reg, factor_x_next;
    logic [FACTOR_W-1:0]       factor_y_reg, factor_y_next;
    logic                      factors_ready_reg, factors_ready_next;

    // transform datapath
    logic signed [COORD_W-1:0] pt_x_reg, pt_x_next, pt_y_reg, pt_y_next;
    logic signed [COORD_W-1:0] res_x_reg, res_x_next;
    logic signed [COORD_W-1:0] x_out_reg, x_out_next, y_out_reg, y_out_next;
    logic                      out_valid_reg, out_valid_next;

    logic                      accept;
    logic [COORD_W-1:0]        ext_x, ext_y;
    logic                      div_start;
    logic [DIVIDEND_W-1:0]     div_dividend;
    logic [FACTOR_W-1:0]       div_divisor;
    div_status_t               div_status;
    logic [FACTOR_W-1:0]       div_quotient;
    logic [FACTOR_W-1:0]       uniform_k;
    logic                      scale_en;
    logic signed [COORD_W-1:0] scale_p, scale_lo, scale_result;
    logic [FACTOR_W-1:0]       scale_f;
    logic                      load_out;

    // extent below the minimum counts as zero (box always keeps min <= max)
    function automatic logic [COORD_W-1:0] extent_of(
        input logic signed [COORD_W-1:0] lo,
        input logic signed [COORD_W-1:0] hi,
        input logic [MINEXT_W-1:0]       min_ext
    );
        logic [COORD_W-1:0] diff;
        diff = COORD_W'(hi - lo);
        return (diff < COORD_W'(min_ext)) ? '0 : diff;
    endfunction

    assign accept      = point_valid && !point_stall;
    assign point_stall = (state_reg != ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign ext_x       = extent_of(min_x_reg, max_x_reg, min_extent_reg);
    assign ext_y       = extent_of(min_y_reg, max_y_reg, min_extent_reg);

    // divider: x axis started from idle, y axis when x finishes
    assign div_dividend = (state_reg == ST_IDLE)
                        ? {box_width_reg, {FRAC_BITS{1'b0}}}
                        : {box_height_reg, {FRAC_BITS{1'b0}}};
    assign div_divisor  = (state_reg == ST_IDLE) ? ext_x : ext_y;

    psfb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_status),
        .quotient (div_quotient)
    );

    // scale unit: x fed in MUL_X, y in MUL_Y, drained in MUL_DRAIN
    assign scale_en = (state_reg == ST_MUL_X) || (state_reg == ST_MUL_Y)
                   || (state_reg == ST_MUL_DRAIN);
    assign scale_p  = (state_reg == ST_MUL_X) ? pt_x_reg : pt_y_reg;
    assign scale_lo = (state_reg == ST_MUL_X) ? min_x_reg : min_y_reg;
    assign scale_f  = (state_reg == ST_MUL_X) ? factor_x_reg : factor_y_reg;

    psfb_scale u_scale (
        .clk    (clk),
        .en     (scale_en),
        .p      (scale_p),
        .lo     (scale_lo),
        .f      (scale_f),
        .result (scale_result)
    );

    // uniform mode: smaller positive factor, else the only positive one
    always_comb
    begin
        if (factor_x_reg != '0 && factor_y_reg != '0)
            uniform_k = (factor_x_reg < factor_y_reg) ? factor_x_reg : factor_y_reg;
        else if (factor_x_reg != '0)
            uniform_k = factor_x_reg;
        else
            uniform_k = factor_y_reg;
    end

    always_comb
    begin
        state_next         = state_reg;
        box_width_next     = box_width_reg;
        box_height_next    = box_height_reg;
        fit_mode_next      = fit_mode_reg;
        min_extent_next    = min_extent_reg;
        min_x_next         = min_x_reg;
        max_x_next         = max_x_reg;
        min_y_next         = min_y_reg;
        max_y_next         = max_y_reg;
        factor_x_next      = factor_x_reg;
        factor_y_next      = factor_y_reg;
        factors_ready_next = factors_ready_reg;
        pt_x_next          = pt_x_reg;
        pt_y_next          = pt_y_reg;
        res_x_next         = res_x_reg;
        x_out_next         = x_out_reg;
        y_out_next         = y_out_reg;
        out_valid_next     = out_valid_reg && result_stall;
        div_start          = 1'b0;
        load_out           = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BOX_WIDTH:  box_width_next  = cfg_data;
                CFG_BOX_HEIGHT: box_height_next = cfg_data;
                CFG_FIT_MODE:   fit_mode_next   = cfg_data[0];
                CFG_MIN_EXTENT: min_extent_next = cfg_data[MINEXT_W-1:0];
                default:        ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_FIRST:
                        begin
                            min_x_next         = x_in;
                            max_x_next         = x_in;
                            min_y_next         = y_in;
                            max_y_next         = y_in;
                            factors_ready_next = 1'b0;
                        end
                        OP_FURTHER:
                        begin
                            if (max_x_reg < x_in) max_x_next = x_in;
                            if (x_in < min_x_reg) min_x_next = x_in;
                            if (max_y_reg < y_in) max_y_next = y_in;
                            if (y_in < min_y_reg) min_y_next = y_in;
                            factors_ready_next = 1'b0;
                        end
                        OP_TRANSFORM:
                        begin
                            pt_x_next = x_in;
                            pt_y_next = y_in;
                            if (factors_ready_reg)
                                state_next = ST_MUL_X;
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = ST_DIV_X;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV_X:
            begin
                if (div_status.done)
                begin
                    factor_x_next = (ext_x == '0) ? '0 : div_quotient;
                    div_start     = 1'b1;
                    state_next    = ST_DIV_Y;
                end
            end
            ST_DIV_Y:
            begin
                if (div_status.done)
                begin
                    factor_y_next = (ext_y == '0) ? '0 : div_quotient;
                    state_next    = ST_PICK;
                end
            end
            ST_PICK:
            begin
                if (fit_mode_reg)
                begin
                    factor_x_next = uniform_k;
                    factor_y_next = uniform_k;
                end
                factors_ready_next = 1'b1;
                state_next         = ST_MUL_X;
            end
            ST_MUL_X:     state_next = ST_MUL_Y;
            ST_MUL_Y:     state_next = ST_MUL_DRAIN;
            ST_MUL_DRAIN:
            begin
                res_x_next = scale_result;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // result register free or being taken this cycle
                if (!out_valid_reg || !result_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (load_out)
        begin
            // uniform mode: a degenerate axis sits at half the box
            x_out_next = (fit_mode_reg && ext_x == '0)
                       ? COORD_W'(box_width_reg >> 1) : res_x_reg;
            y_out_next = (fit_mode_reg && ext_y == '0)
                       ? COORD_W'(box_height_reg >> 1) : scale_result;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            box_width_reg     <= BOX_W'(6553600);
            box_height_reg    <= BOX_W'(6553600);
            fit_mode_reg      <= 1'b1;
            min_extent_reg    <= MINEXT_W'(1);
            min_x_reg         <= '0;
            max_x_reg         <= '0;
            min_y_reg         <= '0;
            max_y_reg         <= '0;
            factor_x_reg      <= '0;
            factor_y_reg      <= '0;
            factors_ready_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            box_width_reg     <= box_width_next;
            box_height_reg    <= box_height_next;
            fit_mode_reg      <= fit_mode_next;
            min_extent_reg    <= min_extent_next;
            min_x_reg         <= min_x_next;
            max_x_reg         <= max_x_next;
            min_y_reg         <= min_y_next;
            max_y_reg         <= max_y_next;
            factor_x_reg      <= factor_x_next;
            factor_y_reg      <= factor_y_next;
            factors_ready_reg <= factors_ready_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pt_x_reg  <= pt_x_next;
        pt_y_reg  <= pt_y_next;
        res_x_reg <= res_x_next;
        x_out_reg <= x_out_next;
        y_out_reg <= y_out_next;
    end

    assign result_valid = out_valid_reg;
    assign x_out        = x_out_reg;
    assign y_out        = y_out_reg;

endmodule

[src/psfb_div.sv]
`timescale 1ns / 1ps
// ============================================================================
// psfb_div: iterative restoring divider
// One quotient bit per cycle; quotient saturates to the factor width.
// ============================================================================
module psfb_div
    import psfb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [FACTOR_W-1:0]   divisor,
    output div_status_t           status,
    output logic [FACTOR_W-1:0]   quotient
);

    logic [DIVIDEND_W-1:0] work_reg, work_next;
    logic [FACTOR_W:0]     rem_reg, rem_next;
    logic [FACTOR_W-1:0]   dvsr_reg, dvsr_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [FACTOR_W:0]     trial;

    always_comb
    begin
        trial     = {rem_reg[FACTOR_W-1:0], work_reg[DIVIDEND_W-1]};
        work_next = work_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, dvsr_reg})
            begin
                rem_next  = trial - {1'b0, dvsr_reg};
                work_next = {work_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                work_next = {work_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
        else if (start)
        begin
            work_next = dividend;
            rem_next  = '0;
            dvsr_next = divisor;
            cnt_next  = DIV_CNT_W'(DIVIDEND_W);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;
    // quotient bits above the factor width mean overflow
    assign quotient = (|work_reg[DIVIDEND_W-1:FACTOR_W]) ? '1 : work_reg[FACTOR_W-1:0];

endmodule

[src/psfb_scale.sv]
`timescale 1ns / 1ps
// ============================================================================
// psfb_scale: shared offset-multiply-saturate unit
// Two register stages: offset magnitude, then product; saturation at output.
// ============================================================================
module psfb_scale
    import psfb_pkg::*;
(
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [COORD_W-1:0]  p,
    input  logic signed [COORD_W-1:0]  lo,
    input  logic [FACTOR_W-1:0]        f,
    output logic signed [COORD_W-1:0]  result
);

    localparam int R_W = PROD_W - FRAC_BITS;

    logic                neg_a_reg;
    logic [COORD_W-1:0]  mag_a_reg;
    logic [FACTOR_W-1:0] f_a_reg;
    logic                neg_b_reg;
    logic [PROD_W-1:0]   prod_b_reg;
    logic                neg;
    logic [COORD_W-1:0]  mag;
    logic [R_W-1:0]      r;
    logic                r_big;

    always_comb
    begin
        neg = (p < lo);
        mag = neg ? COORD_W'(lo - p) : COORD_W'(p - lo);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_a_reg  <= neg;
            mag_a_reg  <= mag;
            f_a_reg    <= f;
            neg_b_reg  <= neg_a_reg;
            prod_b_reg <= PROD_W'(mag_a_reg) * PROD_W'(f_a_reg);
        end
    end

    // truncate fraction, saturate to the signed output range
    always_comb
    begin
        r     = prod_b_reg[PROD_W-1:FRAC_BITS];
        r_big = |r[R_W-1:COORD_W-1];
        if (neg_b_reg)
            result = r_big ? {1'b1, {(COORD_W-1){1'b0}}} : (COORD_W'(0) - r[COORD_W-1:0]);
        else
            result = r_big ? {1'b0, {(COORD_W-1){1'b1}}} : r[COORD_W-1:0];
    end

endmodule

[src/psfb_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// psfb_checker: port-level checks for point_set_fit_to_box
// Result hold under stall, ready behavior per opcode, config always taken.
// ============================================================================
module psfb_checker
    import psfb_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       point_valid,
    input logic                       point_stall,
    input logic [1:0]                 opcode,
    input logic                       result_valid,
    input logic                       result_stall,
    input logic signed [COORD_W-1:0]  x_out,
    input logic signed [COORD_W-1:0]  y_out,
    input logic                       cfg_valid,
    input logic                       cfg_ready
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(x_out) && $stable(y_out))
        else $error("stalled result changed");

    a_measure_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !point_stall && opcode != OP_TRANSFORM |=> !point_stall)
        else $error("measure transaction left the block busy");

    a_transform_busy: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !point_stall && opcode == OP_TRANSFORM |=> point_stall)
        else $error("transform transaction did not occupy the block");

    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(point_stall))
        else $error("result appeared without a transform in flight");

    a_cfg_taken: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind point_set_fit_to_box psfb_checker u_psfb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .opcode       (opcode),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .x_out        (x_out),
    .y_out        (y_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);
